### src/sorted_key_table_find_insert_defines.svh
// Assertion helpers shared by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_FIND_INSERT_DEFINES_SVH
`define SORTED_KEY_TABLE_FIND_INSERT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SKT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/skt_pkg.sv
package skt_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int KEY_HIGH_W   = 32;
    localparam int KEY_MID_W    = 64;
    localparam int KEY_LOW_W    = 64;
    localparam int KEY_W        = KEY_HIGH_W + KEY_MID_W + KEY_LOW_W;

    localparam int POSITION_W   = 11;
    localparam int HANDLE_W     = 10;
    localparam int ENTRY_CNT_W  = 11;

    localparam int IN_TDATA_W   = 160;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 3;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // High word in the top bits so a packed compare orders keys big-endian.
    typedef struct packed {
        logic [KEY_HIGH_W-1:0] high;
        logic [KEY_MID_W-1:0]  mid;
        logic [KEY_LOW_W-1:0]  low;
    } key_t;

endpackage

### src/skt_store.sv
module skt_store #(
    parameter int DEPTH = skt_pkg::CAPACITY_DEF,
    parameter int DW    = skt_pkg::KEY_W + $clog2(skt_pkg::CAPACITY_DEF)
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/sorted_key_table_find_insert.sv
// Sorted key table: holds up to CAPACITY distinct 160-bit keys in ascending
// big-endian order in one synchronous RAM (one read and one write port).
// Slave channel: s_axis_tdata carries the key, s_axis_tuser the operation
// (find, or find and insert when absent). Master channel: one result beat
// per input beat, in order, with flags in m_axis_tuser and position, handle
// and entry count in m_axis_tdata.
// Each item is accepted, then searched by binary-search probes (RAM read,
// then compare), at most ceil(log2(count+1)) of them, then resolved unless
// found. An insert into a non-full table shifts the entries at and above
// the position one slot up, one entry per cycle through the RAM port pair,
// then writes the new key; last the result loads the output register.
// One item is in work at a time; s_axis_tready is high only when idle.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished item waits until that register is free. Once the result is
// loaded, the next item may be accepted and searched behind it.
// Reset empties the table (count zero) at once; RAM contents are not
// cleared, since only entries below the count are ever read.
`include "sorted_key_table_find_insert_defines.svh"

module sorted_key_table_find_insert #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] key_high, [95:32] key_mid, [159:96] key_low
    input  logic [skt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [10:0] position, [20:11] handle, [31:21] entry_count
    output logic [skt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] found, [1] inserted, [2] table_full
    output logic [skt_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = AW;
    localparam int DW = KEY_W + HW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_RESOLVE = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_TAIL    = 3'd5;
    localparam logic [2:0] S_INSERT  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic          op_reg, op_next;
    key_t          key_reg, key_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic          found_reg, found_next;
    logic          inserted_reg, inserted_next;
    logic          full_reg, full_next;
    logic [HW-1:0] handle_reg, handle_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] sh_idx_reg, sh_idx_next;
    logic [AW-1:0] sh_wr_reg, sh_wr_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_TUSER_W-1:0] out_user_reg, out_user_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    logic [CW-1:0] mid_calc;
    key_t          rd_key;
    logic [HW-1:0] rd_handle;
    logic          in_beat;

    skt_store #(
        .DEPTH (CAPACITY),
        .DW    (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_key    = key_t'(rd_data[DW-1 -: KEY_W]);
    assign rd_handle = rd_data[HW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        inserted_next  = inserted_reg;
        full_next      = full_reg;
        handle_next    = handle_reg;
        count_next     = count_reg;
        sh_idx_next    = sh_idx_reg;
        sh_wr_next     = sh_wr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        wr_en          = 1'b0;
        wr_addr        = sh_wr_reg;
        wr_data        = rd_data;
        rd_addr        = mid_calc[AW-1:0];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next       = s_axis_tuser;
                    key_next      = key_t'({s_axis_tdata[31:0], s_axis_tdata[95:32],
                                            s_axis_tdata[159:96]});
                    lo_next       = '0;
                    hi_next       = count_reg;
                    found_next    = 1'b0;
                    inserted_next = 1'b0;
                    full_next     = 1'b0;
                    handle_next   = '0;
                    state_next    = (count_reg != '0) ? S_READ : S_RESOLVE;
                end
            end
            S_READ:
            begin
                rd_addr    = mid_calc[AW-1:0];
                mid_next   = mid_calc[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_reg == rd_key)
                begin
                    found_next  = 1'b1;
                    lo_next     = CW'(mid_reg);
                    handle_next = rd_handle;
                    state_next  = S_DONE;
                end
                else if (key_reg < rd_key)
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = (lo_reg < CW'(mid_reg)) ? S_READ : S_RESOLVE;
                end
                else
                begin
                    lo_next    = CW'(mid_reg) + 1'b1;
                    state_next = ((CW'(mid_reg) + 1'b1) < hi_reg) ? S_READ : S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (op_reg == OP_FIND)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    full_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (count_reg > lo_reg)
                begin
                    sh_idx_next = AW'(count_reg - 1'b1);
                    state_next  = S_SHIFT;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_SHIFT:
            begin
                // write back the entry read last cycle one slot up
                wr_en       = (sh_idx_reg != AW'(count_reg - 1'b1));
                wr_addr     = sh_wr_reg;
                rd_addr     = sh_idx_reg;
                sh_wr_next  = sh_idx_reg + 1'b1;
                if (sh_idx_reg == lo_reg[AW-1:0])
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    sh_idx_next = sh_idx_reg - 1'b1;
                end
            end
            S_TAIL:
            begin
                wr_en      = 1'b1;
                wr_addr    = sh_wr_reg;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                wr_en         = 1'b1;
                wr_addr       = lo_reg[AW-1:0];
                wr_data       = {key_reg, count_reg[HW-1:0]};
                handle_next   = count_reg[HW-1:0];
                count_next    = count_reg + 1'b1;
                inserted_next = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ENTRY_CNT_W'(count_reg), HANDLE_W'(handle_reg),
                                      POSITION_W'(lo_reg)};
                    out_user_next  = {full_reg, inserted_reg, found_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        inserted_reg <= inserted_next;
        full_reg     <= full_next;
        handle_reg   <= handle_next;
        sh_idx_reg   <= sh_idx_next;
        sh_wr_reg    <= sh_wr_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    `SKT_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `SKT_ASSERT(a_no_write_in_search,
                !((state_reg == S_READ || state_reg == S_CMP) && wr_en),
                "RAM write during search")
    `SKT_ASSERT(a_shift_ports_apart,
                !(state_reg == S_SHIFT && wr_en && wr_addr == rd_addr),
                "shift reads and writes one entry")
    `SKT_ASSERT_NEXT(a_insert_counts, state_reg == S_INSERT,
                     count_reg == CW'($past(count_reg) + 1'b1),
                     "insert did not advance count")
    `SKT_ASSERT_NEXT(a_idle_count_stable, state_reg == S_IDLE,
                     count_reg == $past(count_reg), "count moved while idle")

endmodule

### dv/tb_sorted_key_table_find_insert.sv
module tb_sorted_key_table_find_insert;

    import skt_pkg::*;

    localparam int TABLE_CAP    = CAPACITY_DEF;
    localparam int MAX_GAP      = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int PRE_FILL_ITEMS = 360;
    localparam int FILL_ITEMS   = 40;
    localparam int TAIL_ITEMS   = 22;

    localparam int FOUND_BIT    = 0;
    localparam int INSERTED_BIT = 1;
    localparam int FULL_BIT     = 2;

    typedef struct {
        logic                   found;
        logic                   inserted;
        logic                   full;
        logic [POSITION_W-1:0]  position;
        logic [HANDLE_W-1:0]    handle;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } lookup_result_t;

    class key_table_scoreboard;
        key_t                entry_keys    [TABLE_CAP];
        logic [HANDLE_W-1:0] entry_handles [TABLE_CAP];
        int unsigned         entry_total;
        lookup_result_t      awaited [$];
        int unsigned         beats_checked;
        int                  errors;

        function void note_lookup(logic op, key_t key);
            lookup_result_t res;
            int unsigned    lo;
            int unsigned    hi;
            int unsigned    mid;
            int unsigned    i;
            bit             hit;
            res.found    = 1'b0;
            res.inserted = 1'b0;
            res.full     = 1'b0;
            res.handle   = '0;
            lo  = 0;
            hi  = entry_total;
            hit = 1'b0;
            while (lo < hi && !hit) begin
                mid = lo + (hi - lo) / 2;
                if (key == entry_keys[mid]) begin
                    hit = 1'b1;
                    lo  = mid;
                end
                else if (key < entry_keys[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            res.position = POSITION_W'(lo);
            if (hit) begin
                res.found  = 1'b1;
                res.handle = entry_handles[lo];
            end
            else if (op == OP_INSERT) begin
                if (entry_total >= TABLE_CAP)
                    res.full = 1'b1;
                else begin
                    for (i = entry_total; i > lo; i--) begin
                        entry_keys[i]    = entry_keys[i-1];
                        entry_handles[i] = entry_handles[i-1];
                    end
                    entry_keys[lo]    = key;
                    entry_handles[lo] = HANDLE_W'(entry_total);
                    res.handle        = HANDLE_W'(entry_total);
                    res.inserted      = 1'b1;
                    entry_total++;
                end
            end
            res.entry_count = ENTRY_CNT_W'(entry_total);
            awaited.push_back(res);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("result beat %0d: %s", beats_checked, what);
        endtask

        task check_result(lookup_result_t got);
            lookup_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result beat with no lookup pending");
                beats_checked++;
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.inserted !== want.inserted)
                report_mismatch($sformatf("inserted %0b, want %0b",
                                          got.inserted, want.inserted));
            if (got.full !== want.full)
                report_mismatch($sformatf("table_full %0b, want %0b", got.full, want.full));
            if (got.position !== want.position)
                report_mismatch($sformatf("position %0d, want %0d",
                                          got.position, want.position));
            if (got.handle !== want.handle)
                report_mismatch($sformatf("handle %0d, want %0d", got.handle, want.handle));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, want %0d",
                                          got.entry_count, want.entry_count));
            beats_checked++;
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = OP_FIND;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    key_table_scoreboard sb = new;

    int unsigned items_sent;
    int unsigned beats_seen;
    int unsigned quiet_cycles;
    bit          send_calm;
    bit          recv_calm;

    sorted_key_table_find_insert #(
        .CAPACITY(TABLE_CAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic key_t make_key(logic [KEY_HIGH_W-1:0] h, logic [KEY_MID_W-1:0] m,
                                      logic [KEY_LOW_W-1:0] l);
        key_t k;
        k.high = h;
        k.mid  = m;
        k.low  = l;
        return k;
    endfunction

    function automatic key_t fresh_key();
        return make_key($urandom, {$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    // Bias toward held keys and their close neighbors so compares go deep.
    function automatic key_t lookup_key();
        key_t        k;
        key_t        held;
        int unsigned sel;
        k = fresh_key();
        if (sb.entry_total == 0)
            return k;
        held = sb.entry_keys[$urandom_range(0, sb.entry_total - 1)];
        sel  = $urandom_range(0, 99);
        if (sel < 40)
            k = held;
        else if (sel < 55) begin
            k = held;
            if ($urandom_range(0, 1) == 1)
                k.low = held.low + 64'd1;
            else
                k.low = held.low - 64'd1;
        end
        else if (sel < 65) begin
            k     = held;
            k.mid = held.mid ^ (64'd1 << $urandom_range(0, KEY_MID_W - 1));
        end
        else if (sel < 80)
            k.high = held.high;
        else if (sel < 88) begin
            k.high = held.high;
            k.mid  = held.mid;
        end
        return k;
    endfunction

    task automatic send_lookup(logic op, key_t key);
        int unsigned gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {key.low, key.mid, key.high};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_lookup(op, key);
        items_sent++;
        if (items_sent % 32 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic random_op();
        return ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_FIND;
    endfunction

    initial
    begin
        logic [KEY_LOW_W-1:0] fill_low;
        fill_low = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, word boundaries, unsigned compares, front inserts
        send_lookup(OP_FIND,   make_key('0, '0, '0));
        send_lookup(OP_FIND,   make_key('1, '1, '1));
        send_lookup(OP_INSERT, make_key('0, '0, 64'd5));
        send_lookup(OP_INSERT, make_key('0, '0, 64'd5));
        send_lookup(OP_INSERT, make_key('0, '0, '0));
        send_lookup(OP_FIND,   make_key('0, '0, '0));
        send_lookup(OP_INSERT, make_key('0, '0, '1));
        send_lookup(OP_INSERT, make_key('0, 64'd1, '0));
        send_lookup(OP_INSERT, make_key('0, 64'h8000_0000_0000_0000, '0));
        send_lookup(OP_INSERT, make_key(32'd1, '0, '0));
        send_lookup(OP_INSERT, make_key(32'h8000_0000, '0, '0));
        send_lookup(OP_INSERT, make_key('1, '0, '0));
        send_lookup(OP_INSERT, make_key('0, '0, 64'h8000_0000_0000_0000));
        send_lookup(OP_INSERT, make_key(32'h7FFF_FFFF, '1, '1));
        send_lookup(OP_FIND,   make_key('0, '0, 64'd6));
        send_lookup(OP_FIND,   make_key('1, '0, '0));
        send_lookup(OP_FIND,   make_key('1, '1, '1));
        send_lookup(OP_FIND,   make_key('0, '0, 64'd4));
        send_lookup(OP_INSERT, make_key(32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
                                        64'hA5A5_A5A5_A5A5_A5A5));
        send_lookup(OP_INSERT, make_key(32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5,
                                        64'h5A5A_5A5A_5A5A_5A5A));

        repeat (PRE_FILL_ITEMS)
            send_lookup(random_op(), lookup_key());

        // Append just below the all-ones key so each insert lands at the end.
        repeat (FILL_ITEMS)
        begin
            send_lookup(OP_INSERT, make_key('1, '1, fill_low));
            fill_low = fill_low + 64'd1;
            if (fill_low % 8 == 7)
                send_lookup(OP_FIND, lookup_key());
        end

        // insertion point past the end, then a long shift from near the front
        send_lookup(OP_FIND,   make_key('1, '1, '1));
        send_lookup(OP_INSERT, make_key('1, '1, '1));
        send_lookup(OP_INSERT, make_key('0, '0, 64'd3));
        repeat (TAIL_ITEMS)
            send_lookup(random_op(), lookup_key());

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_sorted_key_table_find_insert: clean");
        else
            $display("tb_sorted_key_table_find_insert: errors");
        $finish;
    end

    initial
    begin
        int unsigned    stall;
        lookup_result_t got;
        wait (rst_n === 1'b1);
        forever begin
            // hold off long enough to back the block up into its input
            if (beats_seen == 60 || beats_seen == 300)
                stall = HOLD_CYCLES;
            else
                stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.found       = m_axis_tuser[FOUND_BIT];
            got.inserted    = m_axis_tuser[INSERTED_BIT];
            got.full        = m_axis_tuser[FULL_BIT];
            got.position    = m_axis_tdata[POSITION_W-1:0];
            got.handle      = m_axis_tdata[POSITION_W +: HANDLE_W];
            got.entry_count = m_axis_tdata[POSITION_W+HANDLE_W +: ENTRY_CNT_W];
            sb.check_result(got);
            beats_seen++;
            if (beats_seen % 32 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_sorted_key_table_find_insert: errors");
            $finish;
        end
    end

endmodule
